// ----- design/dpa_pkg.sv -----
// shared types, constants and codes of the dynamic partition allocator
`timescale 1ns / 1ps
package dpa_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 128;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // field widths
    localparam int ADDR_BITS = 20;
    localparam int JOB_W     = 16;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // fit policy codes
    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_BEST  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = CFG_IDX_W'(1);

    // reset value of the total size
    localparam logic [ADDR_BITS-1:0] TOTAL_RESET = ADDR_BITS'(1024);

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_BAD_ARG   = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_FULL      = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = STATUS_W'(4);

    // one partition table entry
    typedef struct packed {
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] size;
        logic                 free;
        logic [JOB_W-1:0]     owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // configuration state handed to the sequencer
    typedef struct packed {
        logic [ADDR_BITS-1:0] total;
        logic                 fit;
        logic                 rebuild;
    } t_cfg;

endpackage

// ----- design/dpa_ram.sv -----
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module dpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/dpa_ctrl.sv -----
// command sequencer: table scan, split shift and free-run merge over the table ram
`timescale 1ns / 1ps
module dpa_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dpa_pkg::t_cfg                    i_cfg,
    input  logic                             i_start,
    input  logic                             i_command,
    input  logic [dpa_pkg::JOB_W-1:0]        i_job_id,
    input  logic [dpa_pkg::ADDR_BITS-1:0]    i_request_size,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [dpa_pkg::STATUS_W-1:0]     o_status,
    output logic [dpa_pkg::ADDR_BITS-1:0]    o_block_start,
    output logic [dpa_pkg::CNT_W-1:0]        o_partition_count,
    output logic                             o_ram_we,
    output logic [dpa_pkg::IDX_W-1:0]        o_ram_waddr,
    output logic [dpa_pkg::ENTRY_W-1:0]      o_ram_wdata,
    output logic [dpa_pkg::IDX_W-1:0]        o_ram_raddr,
    input  logic [dpa_pkg::ENTRY_W-1:0]      i_ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_WR_NEW,
        S_WR_PICK,
        S_MERGE,
        S_MERGE_END
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [dpa_pkg::STATUS_W-1:0]    r_status, n_status;
    logic [dpa_pkg::ADDR_BITS-1:0]   r_start_out, n_start_out;
    logic [dpa_pkg::CNT_W-1:0]       r_count, n_count;
    logic                            r_fresh, n_fresh;
    logic                            r_rd_zero, n_rd_zero;
    logic                            r_found, n_found;
    logic                            r_first, n_first;
    logic                            r_cmd, n_cmd;
    logic [dpa_pkg::JOB_W-1:0]       r_job, n_job;
    logic [dpa_pkg::ADDR_BITS-1:0]   r_need, n_need;
    logic [dpa_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic [dpa_pkg::IDX_W-1:0]       r_pick, n_pick;
    logic [dpa_pkg::IDX_W-1:0]       r_wp, n_wp;
    dpa_pkg::t_entry                 r_pick_e, n_pick_e;
    dpa_pkg::t_entry                 r_acc, n_acc;

    dpa_pkg::t_entry                 rd_e;
    dpa_pkg::t_entry                 init_e;
    dpa_pkg::t_entry                 cur_e;
    dpa_pkg::t_entry                 wdata;
    logic [dpa_pkg::IDX_W-1:0]       last_idx;
    logic                            last;
    logic                            fit;
    logic                            take;
    logic                            hit;
    logic                            found_now;
    logic [dpa_pkg::IDX_W-1:0]       pick_now;
    dpa_pkg::t_entry                 pick_e_now;

    // entry zero reads as the rebuilt partition until it is first written
    always_comb begin
        init_e       = '0;
        init_e.size  = i_cfg.total;
        init_e.free  = 1'b1;
        rd_e         = (r_fresh && r_rd_zero) ? init_e : dpa_pkg::t_entry'(i_ram_rdata);
    end

    // shared compare unit for the scan
    always_comb begin
        last_idx   = dpa_pkg::IDX_W'(r_count - dpa_pkg::CNT_W'(1));
        last       = (r_idx == last_idx);
        fit        = rd_e.free && (rd_e.size >= r_need);
        take       = fit && (!r_found ||
                     (i_cfg.fit == dpa_pkg::FIT_BEST && rd_e.size < r_pick_e.size));
        hit        = !rd_e.free && (rd_e.owner == r_job);
        found_now  = r_found || take;
        pick_now   = take ? r_idx : r_pick;
        pick_e_now = take ? rd_e : r_pick_e;
        cur_e      = rd_e;
        if (r_idx == r_pick) begin
            cur_e.free  = 1'b1;
            cur_e.owner = '0;
        end
    end

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_done      = 1'b0;
        n_status    = r_status;
        n_start_out = r_start_out;
        n_count     = r_count;
        n_fresh     = r_fresh;
        n_found     = r_found;
        n_first     = r_first;
        n_cmd       = r_cmd;
        n_job       = r_job;
        n_need      = r_need;
        n_idx       = r_idx;
        n_pick      = r_pick;
        n_wp        = r_wp;
        n_pick_e    = r_pick_e;
        n_acc       = r_acc;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx;
        wdata       = rd_e;
        o_ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_command;
                    n_job   = i_job_id;
                    n_need  = i_request_size;
                    n_idx   = '0;
                    n_found = 1'b0;
                    if (i_command == dpa_pkg::CMD_ALLOC &&
                        (i_job_id == '0 || i_request_size == '0)) begin
                        n_status    = dpa_pkg::ST_BAD_ARG;
                        n_start_out = '0;
                        n_done      = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                        n_busy  = 1'b1;
                    end
                end
            end

            S_SCAN: begin
                o_ram_raddr = r_idx + 1'b1;
                if (r_cmd == dpa_pkg::CMD_ALLOC) begin
                    if (take) begin
                        n_pick   = r_idx;
                        n_pick_e = rd_e;
                        n_found  = 1'b1;
                    end
                    if (last || (take && i_cfg.fit == dpa_pkg::FIT_FIRST)) begin
                        if (!found_now) begin
                            n_state     = S_IDLE;
                            n_busy      = 1'b0;
                            n_done      = 1'b1;
                            n_status    = dpa_pkg::ST_NO_SPACE;
                            n_start_out = '0;
                        end else if (pick_e_now.size == r_need) begin
                            n_state = S_WR_PICK;
                        end else if (r_count == dpa_pkg::CNT_W'(dpa_pkg::TABLE_ENTRIES)) begin
                            n_state     = S_IDLE;
                            n_busy      = 1'b0;
                            n_done      = 1'b1;
                            n_status    = dpa_pkg::ST_FULL;
                            n_start_out = '0;
                        end else if (pick_now == last_idx) begin
                            n_state = S_WR_NEW;
                        end else begin
                            // move entries up from the top, one a cycle
                            n_state     = S_SHIFT;
                            n_idx       = last_idx;
                            o_ram_raddr = last_idx;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    if (hit) begin
                        n_pick      = r_idx;
                        n_state     = S_MERGE;
                        n_idx       = '0;
                        n_wp        = '0;
                        n_first     = 1'b1;
                        o_ram_raddr = '0;
                    end else if (last) begin
                        n_state     = S_IDLE;
                        n_busy      = 1'b0;
                        n_done      = 1'b1;
                        n_status    = dpa_pkg::ST_NOT_FOUND;
                        n_start_out = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            S_SHIFT: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx + 1'b1;
                wdata       = rd_e;
                if (r_idx == r_pick + 1'b1) begin
                    n_state = S_WR_NEW;
                end else begin
                    o_ram_raddr = r_idx - 1'b1;
                    n_idx       = r_idx - 1'b1;
                end
            end

            S_WR_NEW: begin
                // remainder of the split partition
                o_ram_we    = 1'b1;
                o_ram_waddr = r_pick + 1'b1;
                wdata.base  = r_pick_e.base + r_need;
                wdata.size  = r_pick_e.size - r_need;
                wdata.free  = 1'b1;
                wdata.owner = '0;
                n_count     = r_count + 1'b1;
                n_state     = S_WR_PICK;
            end

            S_WR_PICK: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_pick;
                wdata.base  = r_pick_e.base;
                wdata.size  = r_need;
                wdata.free  = 1'b0;
                wdata.owner = r_job;
                n_state     = S_IDLE;
                n_busy      = 1'b0;
                n_done      = 1'b1;
                n_status    = dpa_pkg::ST_OK;
                n_start_out = r_pick_e.base;
            end

            S_MERGE: begin
                // stream the table through an accumulator, folding free runs
                o_ram_raddr = r_idx + 1'b1;
                if (r_first) begin
                    n_acc   = cur_e;
                    n_first = 1'b0;
                end else if (r_acc.free && cur_e.free) begin
                    n_acc.size = r_acc.size + cur_e.size;
                end else begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_wp;
                    wdata       = r_acc;
                    n_wp        = r_wp + 1'b1;
                    n_acc       = cur_e;
                end
                if (last) begin
                    n_state = S_MERGE_END;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_MERGE_END: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_wp;
                wdata       = r_acc;
                n_count     = dpa_pkg::CNT_W'(r_wp) + dpa_pkg::CNT_W'(1);
                n_state     = S_IDLE;
                n_busy      = 1'b0;
                n_done      = 1'b1;
                n_status    = dpa_pkg::ST_OK;
                n_start_out = '0;
            end

            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase

        // first write of entry zero ends the rebuilt view
        if (o_ram_we && o_ram_waddr == '0) begin
            n_fresh = 1'b0;
        end
        // total size write rebuilds the table
        if (i_cfg.rebuild) begin
            n_count = dpa_pkg::CNT_W'(1);
            n_fresh = 1'b1;
        end
        n_rd_zero = (o_ram_raddr == '0);
    end

    assign o_ram_wdata = wdata;

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        r_start_out <= n_start_out;
        r_status    <= n_status;
        r_found     <= n_found;
        r_first     <= n_first;
        r_cmd       <= n_cmd;
        r_job       <= n_job;
        r_need      <= n_need;
        r_idx       <= n_idx;
        r_pick      <= n_pick;
        r_wp        <= n_wp;
        r_pick_e    <= n_pick_e;
        r_acc       <= n_acc;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_count   <= dpa_pkg::CNT_W'(1);
            r_fresh   <= 1'b1;
            r_rd_zero <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_busy    <= n_busy;
            r_done    <= n_done;
            r_count   <= n_count;
            r_fresh   <= n_fresh;
            r_rd_zero <= n_rd_zero;
        end
    end

    assign o_busy            = r_busy;
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_block_start     = r_start_out;
    assign o_partition_count = r_count;

endmodule

// ----- design/dynamic_partition_allocator.sv -----
// top level of the dynamic partition allocator: configuration registers and table ram
`timescale 1ns / 1ps
// Keeps an ordered table of up to 128 contiguous partitions and serves one
// allocate or release item at a time. An item is taken when i_start is high
// and o_busy is low; its single result appears for one cycle with o_done.
// The work is sequenced over a table ram with one read and one write port
// that yields one entry per cycle: an allocate scans up to the current entry
// count (first fit stops at the first match), and a split then moves the
// entries above the chosen one up by one place at one entry a cycle, then
// writes the remainder and the chosen entry. A release scans to the job's
// partition and then streams the whole table once to fold adjacent free
// partitions. A rejected argument returns its result in the cycle after
// the item. The result cannot be stalled and must be captured in its strobe
// cycle.
// Configuration writes are taken whenever o_busy is low; writing total_size
// rebuilds the table at once, with no clearing pass.
module dynamic_partition_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic                             i_command,
    input  logic [dpa_pkg::JOB_W-1:0]        i_job_id,
    input  logic [dpa_pkg::ADDR_BITS-1:0]    i_request_size,
    output logic                             o_done,
    output logic [dpa_pkg::STATUS_W-1:0]     o_status,
    output logic [dpa_pkg::ADDR_BITS-1:0]    o_block_start,
    output logic [dpa_pkg::CNT_W-1:0]        o_partition_count,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dpa_pkg::ADDR_BITS-1:0]    i_cfg_data
);

    logic [dpa_pkg::ADDR_BITS-1:0] r_total;
    logic                          r_fit;
    logic                          cfg_wr;
    dpa_pkg::t_cfg                 cfg;
    logic                          busy;
    logic                          ram_we;
    logic [dpa_pkg::IDX_W-1:0]     ram_waddr;
    logic [dpa_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [dpa_pkg::IDX_W-1:0]     ram_raddr;
    logic [dpa_pkg::ENTRY_W-1:0]   ram_rdata;

    // configuration registers
    assign o_cfg_ready = ~busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= dpa_pkg::TOTAL_RESET;
            r_fit   <= dpa_pkg::FIT_FIRST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                dpa_pkg::REG_TOTAL_SIZE: r_total <= i_cfg_data;
                dpa_pkg::REG_FIT_POLICY: r_fit   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.total   = r_total;
        cfg.fit     = r_fit;
        cfg.rebuild = cfg_wr && (i_cfg_index == dpa_pkg::REG_TOTAL_SIZE);
    end

    // sequencer
    dpa_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_start           (i_start),
        .i_command         (i_command),
        .i_job_id          (i_job_id),
        .i_request_size    (i_request_size),
        .o_busy            (busy),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_block_start     (o_block_start),
        .o_partition_count (o_partition_count),
        .o_ram_we          (ram_we),
        .o_ram_waddr       (ram_waddr),
        .o_ram_wdata       (ram_wdata),
        .o_ram_raddr       (ram_raddr),
        .i_ram_rdata       (ram_rdata)
    );

    // partition table
    dpa_ram #(
        .WIDTH (dpa_pkg::ENTRY_W),
        .DEPTH (dpa_pkg::TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_busy = busy;

endmodule

// ----- design/dpa_checker.sv -----
// port level checks of the dynamic partition allocator
`timescale 1ns / 1ps
module dpa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_start,
    input logic                             o_busy,
    input logic                             o_done,
    input logic [dpa_pkg::STATUS_W-1:0]     o_status,
    input logic [dpa_pkg::ADDR_BITS-1:0]    o_block_start,
    input logic [dpa_pkg::CNT_W-1:0]        o_partition_count
);

    // an accepted item is either in progress or answered next cycle
    a_accept_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("accepted item neither in progress nor answered");

    // a result only ends the work of an item
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    // the table never empties nor overflows
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_partition_count != '0 &&
                    o_partition_count <= dpa_pkg::CNT_W'(dpa_pkg::TABLE_ENTRIES)))
        else $error("partition count out of range");

    // a failed command reports no address
    a_fail_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != dpa_pkg::ST_OK) |-> (o_block_start == '0))
        else $error("start address on a failed command");

    // table full only reported with a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == dpa_pkg::ST_FULL) |->
            (o_partition_count == dpa_pkg::CNT_W'(dpa_pkg::TABLE_ENTRIES)))
        else $error("table full with free entries");

endmodule

bind dynamic_partition_allocator dpa_checker u_dpa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_start           (i_start),
    .o_busy            (o_busy),
    .o_done            (o_done),
    .o_status          (o_status),
    .o_block_start     (o_block_start),
    .o_partition_count (o_partition_count)
);
